>>> src/msf_pkg.sv
// Package for the mode superposition field core: sizes, action codes,
// CORDIC constants and the arctangent table. No dependencies.
package msf_pkg;

    localparam int MAX_MODES    = 64;
    localparam int POINTS       = 512;
    localparam int CORDIC_STEPS = 16;

    localparam int MODE_W  = 6;
    localparam int POINT_W = 9;
    localparam int ADDR_W  = MODE_W + POINT_W;
    localparam int FIELD_W = 38;
    localparam int STEP_W  = 5;

    localparam logic [1:0] ACT_LOAD_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_LOAD_INDEX  = 2'd1;
    localparam logic [1:0] ACT_SET_DEPTH   = 2'd2;
    localparam logic [1:0] ACT_EVALUATE    = 2'd3;

    localparam logic [31:0] INV_TWO_PI_Q34  = 32'd2734261102;
    localparam logic [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Request from the sequencer to the CORDIC unit, and its answer.
    typedef struct packed {
        logic        start;
        logic [31:0] turns;
    } cordic_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] cos_q15;
        logic [15:0] sin_q15;
    } cordic_rsp_t;

    function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2F9;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> src/msf_cordic.sv
// Iterative CORDIC rotation: one step per cycle, CORDIC_STEPS steps in all.
// Depends on msf_pkg for the arctangent table and request types.
module msf_cordic
    import msf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cordic_req_t req,
    output cordic_rsp_t rsp
);

    logic               busy_reg, busy_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [32:0] a_reg, a_next;
    logic               done_reg, done_next;
    logic [15:0]        cos_reg, cos_next, sin_reg, sin_next;

    function automatic logic [15:0] to_q15(input logic signed [33:0] v);
        logic signed [34:0] r;
        begin
            r = ($signed({v[33], v}) + 35'sd16384) >>> 15;
            if (r > 35'sd32767)
                return 16'h7FFF;
            else if (r < -35'sd32768)
                return 16'h8000;
            return r[15:0];
        end
    endfunction

    always_comb
    begin
        logic signed [32:0] a0;
        logic signed [33:0] dx, dy;
        busy_next = busy_reg;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        a_next    = a_reg;
        done_next = 1'b0;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        a0 = {req.turns[31], req.turns};
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            y_next    = '0;
            // fold beyond a quarter turn: remove half a turn, negate start
            if (a0 > 33'sh040000000)
            begin
                a_next = a0 - 33'sh080000000;
                x_next = -CORDIC_GAIN_Q30;
            end
            else if (a0 < -33'sh040000000)
            begin
                a_next = a0 + 33'sh080000000;
                x_next = -CORDIC_GAIN_Q30;
            end
            else
            begin
                a_next = a0;
                x_next = CORDIC_GAIN_Q30;
            end
        end
        else if (busy_reg)
        begin
            if (!a_reg[32])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                a_next = a_reg - $signed({1'b0, atan_turns(step_reg)});
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                a_next = a_reg + $signed({1'b0, atan_turns(step_reg)});
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                cos_next  = to_q15(x_next);
                sin_next  = to_q15(y_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        a_reg   <= a_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.cos_q15 = cos_reg;
    assign rsp.sin_q15 = sin_reg;

endmodule

>>> src/mode_superposition_field_core.sv
// Top level of the mode superposition field core: stores, sequencer, MAC.
// Depends on msf_pkg and msf_cordic.
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+----
//  in      | in_valid, in_stall, action, mode, point,        | in
//          | sample, index_value, depth                      |
//  out     | out_valid, out_stall, field_real, field_imag,   | out
//          | result_point                                    |
//  cfg     | cfg_we, cfg_wdata (mode_count)                  | in
//
// Set depth runs each of the 64 modes through an index read, phase
// multiply and start, then the 16-step CORDIC and its done strobe.
// Evaluate reads one profile sample per cycle from the simple dual-port
// profile memory into one shared complex MAC, for min(mode_count, 64)
// modes; with no mode to sum it goes straight to the drain.
// Reset clears control and phasors (valid bits); profile and index
// memories are not cleared. A finished result sits in the output register
// while the next item is taken; in_stall is high whenever the core is not
// idle, and an evaluation waits while that register is full and stalled.
module mode_superposition_field_core
    import msf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [6:0]                cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                action,
    input  logic [MODE_W-1:0]         mode,
    input  logic [POINT_W-1:0]        point,
    input  logic signed [15:0]        sample,
    input  logic [15:0]               index_value,
    input  logic [31:0]               depth,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [FIELD_W-1:0] field_real,
    output logic signed [FIELD_W-1:0] field_imag,
    output logic [POINT_W-1:0]        result_point
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_IDXRD = 4'd1;
    localparam logic [3:0] S_MUL0  = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_TURN  = 4'd4;
    localparam logic [3:0] S_CORD  = 4'd5;
    localparam logic [3:0] S_EVAL  = 4'd6;
    localparam logic [3:0] S_DRAIN = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_ROT   = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [6:0]         count_reg;
    logic [MODE_W:0]    m_reg, m_next;
    logic [31:0]        depth_reg;
    logic [POINT_W-1:0] point_reg;

    logic [15:0] profile_mem [MAX_MODES*POINTS];
    logic [15:0] index_mem [MAX_MODES];
    logic [15:0] cos_mem [MAX_MODES];
    logic [15:0] sin_mem [MAX_MODES];
    logic [MAX_MODES-1:0] ph_valid_reg;

    logic [15:0]        prof_rd_reg, idx_rd_reg;
    logic [15:0]        cos_rd_reg, sin_rd_reg;
    logic               prof_v_reg;
    logic [MODE_W-1:0]  prof_m_reg;
    logic [47:0]        phase_reg;
    logic [55:0]        plo_reg;
    logic [47:0]        phi_reg;
    logic [31:0]        turns_reg;
    logic signed [FIELD_W+1:0] re_reg, im_reg;
    logic signed [31:0] pr_reg, pi_reg;
    logic               p_v_reg;

    logic               out_valid_reg;
    logic signed [FIELD_W-1:0] fr_reg, fi_reg;
    logic [POINT_W-1:0] rp_reg;

    cordic_req_t creq;
    cordic_rsp_t crsp;

    logic [6:0] active;
    logic       accept, mode_done, start_out;
    logic signed [15:0] cs, sn;

    assign active   = (count_reg > 7'(MAX_MODES)) ? 7'(MAX_MODES) : count_reg;
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign mode_done = (m_reg[MODE_W-1:0] == MODE_W'(MAX_MODES - 1));
    assign start_out = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    msf_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));
    assign creq.start = (state_reg == S_ROT);
    assign creq.turns = turns_reg;

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    m_next = '0;
                    priority if (action == ACT_SET_DEPTH)
                        state_next = S_IDXRD;
                    else if (action == ACT_EVALUATE)
                        state_next = ({1'b0, point} < (POINT_W+1)'(POINTS) &&
                                      active != 0) ? S_EVAL : S_DRAIN;
                    else
                        state_next = S_IDLE;
                end
            S_IDXRD: state_next = S_MUL0;
            S_MUL0:  state_next = S_MUL1;
            S_MUL1:  state_next = S_TURN;
            S_TURN:  state_next = S_ROT;
            S_ROT:   state_next = S_CORD;
            S_CORD:
                if (crsp.done)
                begin
                    m_next     = m_reg + 1'b1;
                    state_next = mode_done ? S_IDLE : S_IDXRD;
                end
            S_EVAL:
            begin
                m_next = m_reg + 1'b1;
                if (m_next == active)
                    state_next = S_DRAIN;
            end
            S_DRAIN: state_next = (prof_v_reg || p_v_reg) ? S_DRAIN : S_OUT;
            S_OUT:   state_next = start_out ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_reg         <= '0;
            count_reg     <= 7'd1;
            ph_valid_reg  <= '0;
            prof_v_reg    <= 1'b0;
            p_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            m_reg     <= m_next;
            if (cfg_we)
                count_reg <= cfg_wdata;
            if (state_reg == S_CORD && crsp.done)
                ph_valid_reg[m_reg[MODE_W-1:0]] <= 1'b1;
            prof_v_reg <= (state_reg == S_EVAL);
            p_v_reg    <= prof_v_reg;
            if (start_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (accept && action == ACT_LOAD_SAMPLE)
            profile_mem[{mode, point}] <= sample;
        prof_rd_reg <= profile_mem[{m_reg[MODE_W-1:0], point_reg}];
        if (accept && action == ACT_LOAD_INDEX)
            index_mem[mode] <= index_value;
        idx_rd_reg <= index_mem[m_reg[MODE_W-1:0]];
        if (state_reg == S_CORD && crsp.done)
        begin
            cos_mem[m_reg[MODE_W-1:0]] <= crsp.cos_q15;
            sin_mem[m_reg[MODE_W-1:0]] <= crsp.sin_q15;
        end
        cos_rd_reg <= cos_mem[m_reg[MODE_W-1:0]];
        sin_rd_reg <= sin_mem[m_reg[MODE_W-1:0]];
    end

    assign cs = ph_valid_reg[prof_m_reg] ? cos_rd_reg : 16'sd0;
    assign sn = ph_valid_reg[prof_m_reg] ? sin_rd_reg : 16'sd0;

    always_ff @(posedge clk)
    begin
        logic [47:0] hi;
        if (accept)
        begin
            depth_reg <= depth;
            point_reg <= point;
            re_reg    <= '0;
            im_reg    <= '0;
        end
        prof_m_reg <= m_reg[MODE_W-1:0];
        // phase = index * depth, then turns = floor(P*C/2^35)
        if (state_reg == S_MUL0)
            phase_reg <= 48'(idx_rd_reg) * 48'(depth_reg);
        if (state_reg == S_MUL1)
        begin
            plo_reg <= 56'(phase_reg[23:0]) * 56'(INV_TWO_PI_Q34);
            phi_reg <= 48'(phase_reg[47:24]) * 48'(INV_TWO_PI_Q34);
        end
        hi = phi_reg + 48'(plo_reg[55:24]);
        if (state_reg == S_TURN)
            turns_reg <= hi[42:11];
        // complex MAC
        pr_reg <= $signed(prof_rd_reg) * cs;
        pi_reg <= $signed(prof_rd_reg) * sn;
        if (p_v_reg)
        begin
            re_reg <= re_reg + 40'(pr_reg);
            im_reg <= im_reg + 40'(pi_reg);
        end
        if (start_out)
        begin
            fr_reg <= (re_reg > 40'sh1FFFFFFFFF) ? 38'sh1FFFFFFFFF :
                      (re_reg < -40'sh2000000000) ? -38'sh2000000000 :
                      re_reg[FIELD_W-1:0];
            fi_reg <= (im_reg > 40'sh1FFFFFFFFF) ? 38'sh1FFFFFFFFF :
                      (im_reg < -40'sh2000000000) ? -38'sh2000000000 :
                      im_reg[FIELD_W-1:0];
            rp_reg <= point_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign field_real   = fr_reg;
    assign field_imag   = fi_reg;
    assign result_point = rp_reg;

endmodule
